### design/speed_ramp_profile_generator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the speed ramp profile generator
// Clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef SPEED_RAMP_PROFILE_GENERATOR_ASSERT_SVH
`define SPEED_RAMP_PROFILE_GENERATOR_ASSERT_SVH

// Same-cycle implication.
`define SRPG_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("srpg assertion failed: same-cycle check");

// Next-cycle implication.
`define SRPG_ASSERT_NXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("srpg assertion failed: next-cycle check");

`endif

### design/srpg_pkg.sv
// ----------------------------------------------------------------------------
// srpg_pkg
// Types and constants shared by the speed ramp profile generator modules.
// ----------------------------------------------------------------------------
package srpg_pkg;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_STOP  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  localparam logic [0:0]  REG_ALPHA         = 1'b0;
  localparam logic [0:0]  REG_FLOOR_SPEED   = 1'b1;
  localparam logic [15:0] ALPHA_LIMIT       = 16'd32768;
  localparam logic [30:0] FLOOR_SPEED_RESET = 31'd163840;

  // Shared multiply/divide unit widths.
  localparam int MD_A_W = 64;
  localparam int MD_B_W = 34;
  localparam int MD_D_W = 32;

  typedef enum logic {MD_MUL, MD_DIV} md_op_t;

  typedef struct packed {
    logic              go;
    md_op_t            op;
    logic [MD_A_W-1:0] a;
    logic [MD_B_W-1:0] b;
  } md_req_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic [MD_A_W+MD_B_W-1:0] prod;
    logic [MD_A_W-1:0]        quot;
  } md_rsp_t;

  typedef struct packed {
    logic [15:0] alpha;
    logic [30:0] floor_speed;
  } srpg_cfg_t;

  typedef struct packed {
    req_t        req;
    logic [31:0] now;
    logic [31:0] speed;
    logic [31:0] target;
    logic [15:0] dur;
  } srpg_item_t;

  typedef struct packed {
    logic [31:0] speed;
    logic        running;
  } srpg_res_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic md_go;
    logic md_busy;
  } srpg_stat_t;

  typedef enum logic [3:0] {
    CS_IDLE, CS_DECODE, CS_START_FIN, CS_CONST_FIN, CS_SM_SETUP, CS_SM_DIV1,
    CS_SM_DIV2, CS_SM_SQ, CS_SM_FRAC, CS_SM_PART, CS_SAT, CS_DONE
  } core_state_t;

  typedef enum logic [1:0] {SC_RISE, SC_FLAT, SC_FALL} seg_t;

endpackage

### design/srpg_muldiv.sv
// ----------------------------------------------------------------------------
// srpg_muldiv
// Bit-serial unsigned shift-add multiplier and restoring divider, one bit
// per cycle. The result is valid in the cycle that done is high.
// ----------------------------------------------------------------------------
module srpg_muldiv import srpg_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  md_req_t req,
  output md_rsp_t rsp
);

  logic              busy;
  logic              done;
  md_op_t            op;
  logic [6:0]        cnt;
  logic [MD_A_W-1:0] a_reg;
  logic [MD_A_W-1:0] hi;
  logic [MD_B_W-1:0] lo;
  logic [MD_D_W-1:0] rem;
  logic [MD_A_W-1:0] quo;
  logic [MD_D_W-1:0] divisor;

  logic [MD_A_W:0]   msum;
  logic [MD_D_W:0]   trial;
  logic [MD_D_W:0]   diff;
  logic              ge;
  logic              last;

  always_comb begin
    msum  = {1'b0, hi} + (lo[0] ? {1'b0, a_reg} : {(MD_A_W+1){1'b0}});
    trial = {rem, quo[MD_A_W-1]};
    diff  = trial - {1'b0, divisor};
    ge    = (trial >= {1'b0, divisor});
    last  = (op == MD_MUL) ? (cnt == 7'(MD_B_W - 1)) : (cnt == 7'(MD_A_W - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        busy    <= 1'b1;
        op      <= req.op;
        cnt     <= '0;
        a_reg   <= req.a;
        hi      <= '0;
        lo      <= req.b;
        rem     <= '0;
        quo     <= req.a;
        divisor <= req.b[MD_D_W-1:0];
      end else if (busy) begin
        if (op == MD_MUL) begin
          {hi, lo} <= {msum, lo[MD_B_W-1:1]};
        end else begin
          rem <= ge ? diff[MD_D_W-1:0] : trial[MD_D_W-1:0];
          quo <= {quo[MD_A_W-2:0], ge};
        end
        cnt <= cnt + 7'd1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.prod = {hi, lo};
  assign rsp.quot = quo;

endmodule

### design/srpg_core.sv
// ----------------------------------------------------------------------------
// srpg_core
// Ramp state and the sequencer that drives the shared multiply/divide unit
// through the start, constant-rate and smooth-profile computations.
// ----------------------------------------------------------------------------
module srpg_core import srpg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  srpg_cfg_t  cfg,
  input  logic       start,
  input  srpg_item_t item,
  input  logic       take,
  output srpg_res_t  res,
  output srpg_stat_t stat
);

  md_req_t md_req;
  md_rsp_t md_rsp;

  srpg_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  core_state_t        state, state_next;
  logic               active, active_next;
  logic signed [31:0] goal, goal_next;
  logic [15:0]        rdur, rdur_next;
  logic signed [49:0] mean, mean_next;
  logic signed [33:0] delta, delta_next;
  logic [31:0]        rwidth, rwidth_next;
  logic [31:0]        stamp, stamp_next;
  logic [31:0]        last, last_next;
  srpg_item_t         r_item, r_item_next;
  logic signed [48:0] acc, acc_next;
  logic [31:0]        s_reg, s_reg_next;
  seg_t               seg, seg_next;
  logic               pass, pass_next;
  logic [30:0]        x_reg, x_reg_next;
  logic [31:0]        res_speed, res_speed_next;

  logic signed [31:0] speed_s, min_s, start_speed;
  logic signed [33:0] delta_new;
  logic [32:0]        dmag_new, dmag;
  logic [15:0]        tdur_fix, a_clamp;
  logic [31:0]        cur;
  logic               reached;
  logic signed [32:0] dt;
  logic [32:0]        tmag;
  logic [48:0]        amag;
  logic               neg_c;
  logic               ratio_ok;
  logic [31:0]        tsel, tms, tq, tfull, dq;
  logic [32:0]        numb;
  logic [29:0]        sf;
  logic [30:0]        frac_sq;
  logic [32:0]        part;
  logic signed [48:0] spart;
  logic               bigc;
  logic [46:0]        stepm;
  logic signed [48:0] stepx;

  always_comb begin
    speed_s     = $signed(r_item.speed);
    min_s       = $signed({1'b0, cfg.floor_speed});
    start_speed = (speed_s < min_s) ? min_s : speed_s;
    delta_new   = 34'($signed(r_item.target)) - 34'(start_speed);
    dmag_new    = delta_new[33] ? 33'(-delta_new) : delta_new[32:0];
    dmag        = delta[33] ? 33'(-delta) : delta[32:0];
    tdur_fix    = (r_item.dur == 16'd0) ? 16'd1 : r_item.dur;
    a_clamp     = (cfg.alpha > ALPHA_LIMIT) ? ALPHA_LIMIT : cfg.alpha;
    cur         = r_item.now - stamp;
    reached     = (delta == 34'sd0) ||
                  (!delta[33] && (speed_s >= goal)) ||
                  (delta[33] && (speed_s <= goal));
    dt          = $signed({1'b0, cur}) - $signed({1'b0, last});
    tmag        = dt[32] ? 33'(-dt) : dt[32:0];
    amag        = mean[49] ? 49'(-mean) : mean[48:0];
    neg_c       = mean[49] ^ dt[32];
    ratio_ok    = (39'(cur) * 39'd100) < (39'(rdur) * 39'd105);
    // Times past the ramp end count as the ramp end.
    tsel        = pass ? last : cur;
    tms         = (tsel > {16'd0, rdur}) ? {16'd0, rdur} : tsel;
    tq          = {tms[15:0], 16'd0};
    tfull       = {rdur, 16'd0};
    dq          = tfull - rwidth;
    numb        = {tq, 1'b0} - {1'b0, rwidth};
    sf          = md_rsp.prod[60:31];
    frac_sq     = (seg == SC_RISE) ? {1'b0, sf} : (31'h4000_0000 - {1'b0, sf});
    part        = md_rsp.prod[62:30];
    spart       = delta[33] ? -$signed({16'd0, part}) : $signed({16'd0, part});
    bigc        = |md_rsp.prod[97:62];
    stepm       = bigc ? 47'h100_0000_0000 : md_rsp.prod[62:16];
    stepx       = neg_c ? -$signed({2'b0, stepm}) : $signed({2'b0, stepm});
  end

  always_comb begin
    state_next     = state;
    active_next    = active;
    goal_next      = goal;
    rdur_next      = rdur;
    mean_next      = mean;
    delta_next     = delta;
    rwidth_next    = rwidth;
    stamp_next     = stamp;
    last_next      = last;
    r_item_next    = r_item;
    acc_next       = acc;
    s_reg_next     = s_reg;
    seg_next       = seg;
    pass_next      = pass;
    x_reg_next     = x_reg;
    res_speed_next = res_speed;
    md_req         = '0;
    md_req.op      = MD_MUL;

    unique case (state)
      CS_IDLE: begin
        if (start) begin
          r_item_next = item;
          state_next  = CS_DECODE;
        end
      end
      CS_DECODE: begin
        unique case (r_item.req)
          REQ_START: begin
            active_next    = 1'b1;
            goal_next      = $signed(r_item.target);
            rdur_next      = tdur_fix;
            delta_next     = delta_new;
            rwidth_next    = 32'(a_clamp) * 32'(tdur_fix);
            stamp_next     = r_item.now;
            last_next      = '0;
            res_speed_next = start_speed;
            md_req.go      = 1'b1;
            md_req.op      = MD_DIV;
            md_req.a       = {15'd0, dmag_new, 16'd0};
            md_req.b       = {18'd0, tdur_fix};
            state_next     = CS_START_FIN;
          end
          REQ_STOP: begin
            active_next    = 1'b0;
            res_speed_next = {1'b0, cfg.floor_speed};
            state_next     = CS_DONE;
          end
          REQ_TICK: begin
            if (!active || reached) begin
              res_speed_next = r_item.speed;
              state_next     = CS_DONE;
            end else if (rwidth == 32'd0) begin
              md_req.go  = 1'b1;
              md_req.op  = MD_MUL;
              md_req.a   = {15'd0, amag};
              md_req.b   = {1'b0, tmag};
              state_next = CS_CONST_FIN;
            end else if (ratio_ok) begin
              pass_next  = 1'b0;
              acc_next   = 49'(speed_s);
              state_next = CS_SM_SETUP;
            end else begin
              res_speed_next = goal;
              last_next      = cur;
              state_next     = CS_DONE;
            end
          end
          default: begin
            res_speed_next = r_item.speed;
            state_next     = CS_DONE;
          end
        endcase
      end
      CS_START_FIN: begin
        if (md_rsp.done) begin
          mean_next  = delta[33] ? -$signed({1'b0, md_rsp.quot[48:0]})
                                 : $signed({1'b0, md_rsp.quot[48:0]});
          state_next = CS_DONE;
        end
      end
      CS_CONST_FIN: begin
        if (md_rsp.done) begin
          acc_next   = 49'(speed_s) + stepx;
          state_next = CS_SAT;
        end
      end
      CS_SM_SETUP: begin
        md_req.go = 1'b1;
        md_req.op = MD_DIV;
        md_req.b  = {2'd0, dq};
        if (tq <= rwidth) begin
          seg_next   = SC_RISE;
          s_reg_next = tq;
          md_req.a   = {2'd0, tq, 30'd0};
          state_next = CS_SM_DIV1;
        end else if (tq > dq) begin
          seg_next   = SC_FALL;
          s_reg_next = tfull - tq;
          md_req.a   = {2'd0, tfull - tq, 30'd0};
          state_next = CS_SM_DIV1;
        end else begin
          seg_next   = SC_FLAT;
          md_req.a   = {2'd0, numb, 29'd0};
          state_next = CS_SM_FRAC;
        end
      end
      CS_SM_DIV1: begin
        if (md_rsp.done) begin
          x_reg_next = md_rsp.quot[30:0];
          md_req.go  = 1'b1;
          md_req.op  = MD_DIV;
          md_req.a   = {2'd0, s_reg, 30'd0};
          md_req.b   = {2'd0, rwidth};
          state_next = CS_SM_DIV2;
        end
      end
      CS_SM_DIV2: begin
        if (md_rsp.done) begin
          md_req.go  = 1'b1;
          md_req.op  = MD_MUL;
          md_req.a   = {33'd0, x_reg};
          md_req.b   = {3'd0, md_rsp.quot[30:0]};
          state_next = CS_SM_SQ;
        end
      end
      CS_SM_SQ: begin
        if (md_rsp.done) begin
          md_req.go  = 1'b1;
          md_req.op  = MD_MUL;
          md_req.a   = {31'd0, dmag};
          md_req.b   = {3'd0, frac_sq};
          state_next = CS_SM_PART;
        end
      end
      CS_SM_FRAC: begin
        if (md_rsp.done) begin
          md_req.go  = 1'b1;
          md_req.op  = MD_MUL;
          md_req.a   = {31'd0, dmag};
          md_req.b   = {3'd0, md_rsp.quot[30:0]};
          state_next = CS_SM_PART;
        end
      end
      CS_SM_PART: begin
        if (md_rsp.done) begin
          // First pass adds the gain up to now, second removes the gain up to the last tick.
          if (!pass) begin
            acc_next   = acc + spart;
            pass_next  = 1'b1;
            state_next = CS_SM_SETUP;
          end else begin
            acc_next   = acc - spart;
            state_next = CS_SAT;
          end
        end
      end
      CS_SAT: begin
        if (acc > 49'sd2147483647) begin
          res_speed_next = 32'h7FFF_FFFF;
        end else if (acc < -49'sd2147483648) begin
          res_speed_next = 32'h8000_0000;
        end else begin
          res_speed_next = acc[31:0];
        end
        last_next  = cur;
        state_next = CS_DONE;
      end
      CS_DONE: begin
        if (take) begin
          state_next = CS_IDLE;
        end
      end
      default: state_next = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= CS_IDLE;
      active <= 1'b0;
      goal   <= '0;
      rdur   <= 16'd1;
      mean   <= '0;
      delta  <= '0;
      rwidth <= '0;
      stamp  <= '0;
      last   <= '0;
      pass   <= 1'b0;
    end else begin
      state  <= state_next;
      active <= active_next;
      goal   <= goal_next;
      rdur   <= rdur_next;
      mean   <= mean_next;
      delta  <= delta_next;
      rwidth <= rwidth_next;
      stamp  <= stamp_next;
      last   <= last_next;
      pass   <= pass_next;
    end
  end

  always_ff @(posedge clk) begin
    r_item    <= r_item_next;
    acc       <= acc_next;
    s_reg     <= s_reg_next;
    seg       <= seg_next;
    x_reg     <= x_reg_next;
    res_speed <= res_speed_next;
  end

  assign res.speed    = res_speed;
  assign res.running  = active;
  assign stat.idle    = (state == CS_IDLE);
  assign stat.done    = (state == CS_DONE);
  assign stat.md_go   = md_req.go;
  assign stat.md_busy = md_rsp.busy;

endmodule

### design/speed_ramp_profile_generator.sv
// ----------------------------------------------------------------------------
// speed_ramp_profile_generator
// Items are taken one at a time: a new item is accepted only once the core is back in idle.
// Stop, idle or finished ticks need no multiply/divide; start, constant-rate and smooth ticks
// wait on the one-bit-per-cycle multiply/divide. Sync reset.
// ----------------------------------------------------------------------------
`include "speed_ramp_profile_generator_assert.svh"

module speed_ramp_profile_generator import srpg_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [30:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // now_ms[31:0], speed_in[63:32], target[95:64], duration_ms[111:96]
  input  logic [111:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // speed_out[31:0]
  output logic [31:0]  m_axis_tdata,
  // running[0]
  output logic         m_axis_tuser
);

  srpg_cfg_t  cfg;
  srpg_item_t item;
  srpg_res_t  res;
  srpg_stat_t stat;
  logic       take;
  logic       accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha       <= '0;
      cfg.floor_speed <= FLOOR_SPEED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ALPHA:       cfg.alpha       <= cfg_data[15:0];
        REG_FLOOR_SPEED: cfg.floor_speed <= cfg_data;
        default: ;
      endcase
    end
  end

  assign item.req    = req_t'(s_axis_tuser);
  assign item.now    = s_axis_tdata[31:0];
  assign item.speed  = s_axis_tdata[63:32];
  assign item.target = s_axis_tdata[95:64];
  assign item.dur    = s_axis_tdata[111:96];

  assign s_axis_tready = stat.idle;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign take          = !m_axis_tvalid || m_axis_tready;

  srpg_core u_core (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .start (accept),
    .item  (item),
    .take  (take),
    .res   (res),
    .stat  (stat)
  );

  // Output register lets the core go back to idle while a result waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (stat.done && take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done && take) begin
      m_axis_tdata <= res.speed;
      m_axis_tuser <= res.running;
    end
  end

  `SRPG_ASSERT_NXT(a_busy_after_accept, accept, !s_axis_tready)
  `SRPG_ASSERT_IMP(a_unit_free_on_go, stat.md_go, !stat.md_busy)
  `SRPG_ASSERT_NXT(a_result_loaded, stat.done && take, m_axis_tvalid)

endmodule

### verif/tb_speed_ramp_profile_generator.sv
// ----------------------------------------------------------------------------
// Testbench for the speed ramp profile generator
// Drives start, stop, tick and none-type transactions under bursty input and a
// stalling output, predicts results with a bit-true model of the ramp arithmetic
// or takes a typed-in expectation, and checks speed and running flag in order.
// ----------------------------------------------------------------------------
module tb_speed_ramp_profile_generator;
  import srpg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [0:0]   cfg_index = REG_ALPHA;
  logic [30:0]  cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = REQ_TICK;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [31:0]  m_axis_tdata;
  logic         m_axis_tuser;

  speed_ramp_profile_generator uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #40ms;
    $display("Simulation FAILED");
    $finish;
  end

  // Shadow copy of the registers and the ramp state.
  logic [15:0] alpha_r = 16'd0;
  logic [30:0] min_r = FLOOR_SPEED_RESET;
  bit          act_r;
  longint      goal_r, delta_r, rate_r;
  longint unsigned dur_r = 1, width_r;
  logic [31:0] stamp_r = '0;
  logic [31:0] last_r = '0;

  srpg_res_t   speed_q[$];
  int          errors = 0;
  int          hold_req = 0;
  logic [31:0] last_speed = '0;
  bit          use_exp = 1'b0;
  srpg_res_t   exp_r;

  function automatic longint unsigned sq_frac(longint unsigned s, b, d);
    longint unsigned x, y;
    x = (s << 30) / d;
    y = (s << 30) / b;
    return (x * y) >> 31;
  endfunction

  function automatic longint ramp_gain(logic [31:0] t);
    longint unsigned tms, tq, big_t, d, fr, mag, part;
    tms = t;
    if (tms > dur_r) tms = dur_r;
    tq = tms << 16;
    big_t = dur_r << 16;
    d = big_t - width_r;
    if (tq <= width_r) fr = sq_frac(tq, width_r, d);
    else if (tq <= d) fr = ((2 * tq - width_r) << 29) / d;
    else fr = (64'd1 << 30) - sq_frac(big_t - tq, width_r, d);
    mag = delta_r < 0 ? -delta_r : delta_r;
    part = (mag * fr) >> 30;
    return delta_r < 0 ? -longint'(part) : longint'(part);
  endfunction

  function automatic longint rate_step(longint dt);
    longint amag, tmag, lim;
    bit neg;
    lim = 64'sh3FFF_FFFF_FFFF_FFFF;
    amag = rate_r < 0 ? -rate_r : rate_r;
    tmag = dt < 0 ? -dt : dt;
    neg = (rate_r < 0) != (dt < 0);
    if (tmag != 0 && amag > lim / tmag)
      return neg ? -(longint'(1) << 40) : (longint'(1) << 40);
    return (rate_r * dt) / 65536;
  endfunction

  function automatic srpg_res_t next_speed(req_t rq, logic [31:0] now, sp, tg,
                                           logic [15:0] du);
    srpg_res_t r;
    longint spd, nxt;
    longint unsigned a, td;
    logic [31:0] cur;
    bit reached;
    spd = $signed(sp);
    r.speed = sp;
    case (rq)
      REQ_START: begin
        a = alpha_r > ALPHA_LIMIT ? ALPHA_LIMIT : alpha_r;
        td = du == 0 ? 1 : du;
        if (spd < longint'(min_r)) spd = min_r;
        act_r = 1'b1;
        goal_r = $signed(tg);
        dur_r = td;
        delta_r = goal_r - spd;
        rate_r = (delta_r * 65536) / longint'(td);
        width_r = a * td;
        stamp_r = now;
        last_r = '0;
        r.speed = spd[31:0];
      end
      REQ_STOP: begin
        act_r = 1'b0;
        r.speed = {1'b0, min_r};
      end
      REQ_TICK: begin
        cur = now - stamp_r;
        reached = (delta_r == 0) || (delta_r > 0 && spd >= goal_r) ||
                  (delta_r < 0 && spd <= goal_r);
        if (act_r && !reached) begin
          if (width_r == 0)
            nxt = spd + rate_step(longint'(cur) - longint'(last_r));
          else if (64'(cur) * 100 < dur_r * 105)
            nxt = spd + ramp_gain(cur) - ramp_gain(last_r);
          else
            nxt = goal_r;
          if (nxt > 64'sh7FFF_FFFF) nxt = 64'sh7FFF_FFFF;
          if (nxt < -64'sh8000_0000) nxt = -64'sh8000_0000;
          r.speed = nxt[31:0];
          last_r = cur;
        end
      end
      default: ;
    endcase
    r.running = act_r;
    return r;
  endfunction

  // Output side: stall mode (always ready, random, mostly stalled) redrawn at random; a long hold-off on request.
  initial begin
    int mode, cnt, hold;
    mode = 0;
    cnt = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold = hold_req;
        hold_req = 0;
      end
      if (cnt == 0) begin
        mode = $urandom_range(0, 2);
        cnt = 64;
      end
      cnt--;
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (mode == 0)
        m_axis_tready <= 1'b1;
      else if (mode == 1)
        m_axis_tready <= $urandom_range(0, 1);
      else
        m_axis_tready <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (speed_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result %h/%b", m_axis_tdata, m_axis_tuser);
      end else begin
        if (m_axis_tdata !== speed_q[0].speed || m_axis_tuser !== speed_q[0].running) begin
          errors++;
          if (errors <= 10)
            $display("Mismatch: expected %h/%b, got %h/%b", speed_q[0].speed,
                     speed_q[0].running, m_axis_tdata, m_axis_tuser);
        end
        void'(speed_q.pop_front());
      end
    end
  end

  int burst_left = 0;

  // Presents one transaction and waits until it is taken; then maybe a gap.
  task automatic send(req_t rq, logic [31:0] now, sp, tg, logic [15:0] du);
    srpg_res_t r;
    int gap;
    s_axis_tdata <= {du, tg, sp, now};
    s_axis_tuser <= rq;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    r = next_speed(rq, now, sp, tg, du);
    // A typed-in expectation replaces the predicted one, the state still advances.
    if (use_exp) r = exp_r;
    last_speed = r.speed;
    speed_q.push_back(r);
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (speed_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [30:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ALPHA) alpha_r = val[15:0];
    else min_r = val;
    @(posedge clk);
  endtask

  typedef struct {
    int          wr_alpha;
    req_t        rq;
    logic [31:0] now, sp, tg;
    logic [15:0] du;
    bit          chk;
    logic [31:0] es;
    bit          er;
  } row_t;

  // Known-result rows carry their expectation; all others use the predictor.
  row_t rows[] = '{
    '{-1, REQ_TICK,  32'd0,    32'd100,        32'd0,          16'd5,     1, 32'd100,        0},
    '{-1, REQ_STOP,  32'd0,    32'd7,          32'd0,          16'd0,     1, 32'd163840,     0},
    '{-1, REQ_NONE,  32'd0,    32'hFFFF_FFFB,  32'd0,          16'd0,     1, 32'hFFFF_FFFB,  0},
    '{-1, REQ_START, 32'd10,   32'd0,          32'd655360,     16'd10,    1, 32'd163840,     1},
    '{-1, REQ_TICK,  32'd13,   32'd163840,     32'd0,          16'd0,     0, 32'd0,          0},
    '{-1, REQ_TICK,  32'd11,   32'd300000,     32'd0,          16'd0,     0, 32'd0,          0},
    '{-1, REQ_TICK,  32'd20,   32'd700000,     32'd0,          16'd0,     1, 32'd700000,     1},
    '{-1, REQ_NONE,  32'd0,    32'd5,          32'd0,          16'd0,     1, 32'd5,          1},
    '{-1, REQ_START, 32'hFFFF_FFF0, 32'h7FFF_FFFF, 32'h8000_0000, 16'd0, 1, 32'h7FFF_FFFF, 1},
    '{-1, REQ_TICK,  32'h0000_0010, 32'h7FFF_FFFF, 32'd0,      16'd0,     0, 32'd0,          0},
    '{-1, REQ_TICK,  32'hFFFF_FFF0, 32'h8000_0000, 32'd0,      16'd0,     0, 32'd0,          0},
    '{-1, REQ_START, 32'd0,    32'd163840,     32'd163840,     16'd100,   1, 32'd163840,     1},
    '{-1, REQ_TICK,  32'd50,   32'd0,          32'd0,          16'd0,     1, 32'd0,          1},
    '{-1, REQ_STOP,  32'd0,    32'd0,          32'd0,          16'd0,     1, 32'd163840,     0},
    '{65535, REQ_START, 32'd1000, 32'hFFF0_0000, 32'h7FFF_0000, 16'd65535, 1, 32'd163840, 1},
    '{-1, REQ_TICK,  32'd9000, 32'd163840,     32'd0,          16'd0,     0, 32'd0,          0},
    '{-1, REQ_TICK,  32'd40000, 32'd0,         32'd0,          16'd0,     0, 32'd0,          0},
    '{-1, REQ_TICK,  32'd70000, 32'd0,         32'd0,          16'd0,     0, 32'd0,          0},
    '{-1, REQ_START, 32'd5,    32'h0100_0000,  32'hFF00_0000,  16'd40,    1, 32'h0100_0000,  1},
    '{-1, REQ_TICK,  32'd9,    32'h0100_0000,  32'd0,          16'd0,     0, 32'd0,          0},
    '{-1, REQ_TICK,  32'd30,   32'h0080_0000,  32'd0,          16'd0,     0, 32'd0,          0},
    '{-1, REQ_TICK,  32'd47,   32'h0080_0000,  32'd0,          16'd0,     1, 32'hFF00_0000,  1}
  };

  localparam int PHASES = 7;
  int unsigned phase_alpha[PHASES] = '{0, 32768, 65535, 1, 6554, 20000, 0};
  int unsigned phase_min[PHASES] = '{0, 31'h7FFF_FFFF, 163840, 1, 65536, 0, 163840};

  initial begin
    logic [31:0] now_t, sp, tg;
    logic [15:0] du;
    int n, k, pick;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].wr_alpha >= 0) begin
        drain();
        write_reg(REG_ALPHA, 31'(rows[i].wr_alpha));
      end
      if (rows[i].chk) begin
        exp_r.speed = rows[i].es;
        exp_r.running = rows[i].er;
        use_exp = 1'b1;
        send(rows[i].rq, rows[i].now, rows[i].sp, rows[i].tg, rows[i].du);
        use_exp = 1'b0;
      end else
        send(rows[i].rq, rows[i].now, rows[i].sp, rows[i].tg, rows[i].du);
    end

    now_t = $urandom;
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_reg(REG_ALPHA, 31'(phase_alpha[p]));
      write_reg(REG_FLOOR_SPEED, 31'(p == 3 ? $urandom : phase_min[p]));
      if (p == 2) hold_req = 400;
      n = 0;
      while (n < 150) begin
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
          // A start followed by a run of closed-loop ticks.
          case ($urandom_range(0, 19))
            0: du = 16'($urandom);
            1: du = 16'd0;
            default: du = 16'($urandom_range(1, 300));
          endcase
          sp = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 22);
          tg = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 24);
          send(REQ_START, now_t, sp, tg, du);
          n++;
          k = $urandom_range(2, 12);
          repeat (k) begin
            if ($urandom_range(0, 15) == 0) now_t = now_t - $urandom_range(0, 50);
            else now_t = now_t + $urandom_range(0, du / 3 + 2);
            sp = ($urandom_range(0, 7) == 0) ? $urandom : last_speed;
            send(REQ_TICK, now_t, sp, $urandom, 16'($urandom));
            n++;
          end
          if ($urandom_range(0, 2) == 0) begin
            send(REQ_STOP, now_t, $urandom, $urandom, 16'($urandom));
            n++;
          end
        end else begin
          send(req_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom, 16'($urandom));
          n++;
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (speed_q.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (errors == 0 && speed_q.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
